>>> hdl/touch_key_event_classifier_core_macros.svh
// assertion macros for the touch/key event classifier
`ifndef TOUCH_KEY_EVENT_CLASSIFIER_CORE_MACROS_SVH
`define TOUCH_KEY_EVENT_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define TKEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while in reset
`define TKEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tkec_pkg.sv
// types, codes and constants shared by the event classifier modules
package tkec_pkg;

  localparam int unsigned MaxDevicesDefault = 64;
  // wide enough to compare a device number against any table size up to 256
  localparam int unsigned DevRangeW = 9;
  localparam int unsigned MaxResults = 3;

  localparam logic [15:0] TapDistanceReset = 16'd20;

  localparam logic [4:0] EvSyn = 5'd0;
  localparam logic [4:0] EvKey = 5'd1;
  localparam logic [4:0] EvAbs = 5'd3;

  localparam logic [9:0] SynReport  = 10'h000;
  localparam logic [9:0] AbsMtX     = 10'h035;
  localparam logic [9:0] AbsMtY     = 10'h036;
  localparam logic [9:0] AbsMtTrack = 10'h039;

  localparam logic [9:0] KeyLowMax  = 10'h0ff;
  localparam logic [9:0] KeyHighMin = 10'h160;
  localparam logic [9:0] KeyHighMax = 10'h265;

  localparam logic [2:0] KindNewDevice = 3'd0;
  localparam logic [2:0] KindTracking  = 3'd1;
  localparam logic [2:0] KindGesture   = 3'd2;
  localparam logic [2:0] KindKey       = 3'd3;
  localparam logic [2:0] KindError     = 3'd4;

  localparam logic [1:0] RegAddrTap = 2'd0;

  typedef struct packed {
    logic [31:0]        event_index;
    logic [5:0]         device_id;
    logic [4:0]         event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         notice_kind;
    logic [5:0]         device_out;
    logic               detail;
    logic [31:0]        first_index;
    logic [31:0]        closing_index;
    logic [9:0]         key_code_out;
    logic signed [31:0] report_value;
    logic signed [7:0]  contacts_before;
    logic               last_of_run;
  } out_word_t;

  typedef struct packed {
    logic               touch_active;
    logic signed [7:0]  contact_count;
    logic signed [31:0] first_tracking_value;
    logic [31:0]        touch_start_index;
    logic               swipe_seen;
    logic signed [31:0] start_x;
    logic               start_x_valid;
    logic signed [31:0] start_y;
    logic               start_y_valid;
    logic               key_pending;
    logic [9:0]         held_key_code;
    logic signed [31:0] held_key_value;
    logic [31:0]        held_key_index;
  } track_state_t;

  // class lookup for the device of the word in the evaluation stage
  typedef struct packed {
    logic in_table;
    logic known;
    logic touch;
  } dev_lookup_t;

  // class record request for a device seen for the first time
  typedef struct packed {
    logic       en;
    logic [5:0] dev;
    logic       touch;
  } dev_write_t;

endpackage

>>> hdl/touch_key_event_classifier_core.sv
// Touch/key event classifier. Each input word is one input-layer event; it is
// registered, evaluated and its result words go out through an output
// register. Events with no result or one result sustain one event per cycle
// while the output is not stalled; an event with n results (at most three,
// on a sync report or a first event from a device) holds the input until its
// last result leaves, one result word per cycle through the single output
// register while not stalled. The device class table is a memory read as
// the word is taken in, with per-entry valid bits cleared at reset, so no
// clearing pass is needed.
module touch_key_event_classifier_core import tkec_pkg::*; #(
  parameter int unsigned MAX_DEVICES = MaxDevicesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "touch_key_event_classifier_core_macros.svh"

  logic                      item_valid_q;
  in_word_t                  item_q;
  logic [1:0]                sel_q;
  track_state_t              state_q;
  logic                      out_valid_q;
  out_word_t                 out_q;
  logic [15:0]               tap_distance_q;

  logic                      accept, out_free, emit, retire;
  logic [1:0]                count;
  out_word_t [MaxResults-1:0] slot;
  out_word_t                 pick;
  track_state_t              state_d;
  dev_write_t                wr;
  dev_write_t                wr_gated;
  dev_lookup_t               look;

  tkec_dev_table #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_dev_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_dev_i   (in_word_i.device_id),
    .look_dev_i (item_q.device_id),
    .wr_i       (wr_gated),
    .look_o     (look)
  );

  tkec_eval u_eval (
    .word_i         (item_q),
    .look_i         (look),
    .state_i        (state_q),
    .tap_distance_i (tap_distance_q),
    .count_o        (count),
    .slot_o         (slot),
    .state_o        (state_d),
    .wr_o           (wr)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = item_valid_q && (count != 2'd0) && out_free;
  // the word leaves once its last result goes out, or at once if it has none
  assign retire   = item_valid_q &&
                    ((count == 2'd0) || (emit && (sel_q == (count - 2'd1))));
  assign in_stall_o = item_valid_q && !retire;
  assign accept     = in_valid_i && !in_stall_o;

  assign wr_gated.en    = wr.en && retire;
  assign wr_gated.dev   = wr.dev;
  assign wr_gated.touch = wr.touch;

  always_comb begin
    pick             = slot[sel_q];
    pick.last_of_run = (sel_q == (count - 2'd1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q   <= 1'b0;
      sel_q          <= '0;
      state_q        <= '0;
      out_valid_q    <= 1'b0;
      tap_distance_q <= TapDistanceReset;
    end else begin
      if (accept) begin
        item_valid_q <= 1'b1;
      end else if (retire) begin
        item_valid_q <= 1'b0;
      end
      if (retire) begin
        sel_q   <= '0;
        state_q <= state_d;
      end else if (emit) begin
        sel_q <= sel_q + 2'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (psel && penable && pwrite && (paddr == RegAddrTap)) begin
        tap_distance_q <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
    end
    if (emit) begin
      out_q <= pick;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == RegAddrTap) ? {16'd0, tap_distance_q} : 32'd0;

  `TKEC_ASSERT_NOW(a_sel_in_range, item_valid_q, sel_q != 2'd3, "result select out of range")
  `TKEC_ASSERT_NEXT(a_item_held, item_valid_q && !retire, item_valid_q && $stable(item_q), "word left before its last result")
  `TKEC_ASSERT_NEXT(a_state_held, !retire, $stable(state_q), "state changed without a word leaving")
  `TKEC_ASSERT_NEXT(a_emit_shown, emit, out_valid_o, "result not presented")

endmodule

>>> hdl/tkec_dev_table.sv
// per-device class table: valid bits in flops, touch/key class bit in a memory
module tkec_dev_table import tkec_pkg::*; #(
  parameter int unsigned MAX_DEVICES = MaxDevicesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  logic [5:0]  rd_dev_i,
  input  logic [5:0]  look_dev_i,
  input  dev_write_t  wr_i,
  output dev_lookup_t look_o
);

  localparam int unsigned IdxW = $clog2(MAX_DEVICES);

  logic [MAX_DEVICES-1:0] valid_q;
  logic                   class_mem [MAX_DEVICES];
  logic                   rd_data_q;
  logic                   fwd_q;
  logic                   fwd_data_q;

  logic [DevRangeW-1:0] rd_wide, wr_wide, look_wide;
  logic [IdxW-1:0]      rd_idx, wr_idx, look_idx;
  logic                 wr_in_table, look_in_table;

  assign rd_wide   = DevRangeW'(rd_dev_i);
  assign wr_wide   = DevRangeW'(wr_i.dev);
  assign look_wide = DevRangeW'(look_dev_i);
  assign rd_idx    = rd_wide[IdxW-1:0];
  assign wr_idx    = wr_wide[IdxW-1:0];
  assign look_idx  = look_wide[IdxW-1:0];

  assign wr_in_table   = wr_wide < DevRangeW'(MAX_DEVICES);
  assign look_in_table = look_wide < DevRangeW'(MAX_DEVICES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      fwd_q      <= 1'b0;
      fwd_data_q <= 1'b0;
    end else begin
      if (wr_i.en && wr_in_table) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        // the word leaving evaluation may record the device just being read
        fwd_q      <= wr_i.en && (wr_i.dev == rd_dev_i);
        fwd_data_q <= wr_i.touch;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_table) begin
      class_mem[wr_idx] <= wr_i.touch;
    end
    if (rd_en_i) begin
      rd_data_q <= class_mem[rd_idx];
    end
  end

  assign look_o.in_table = look_in_table;
  assign look_o.known    = look_in_table && valid_q[look_idx];
  assign look_o.touch    = fwd_q ? fwd_data_q : rd_data_q;

endmodule

>>> hdl/tkec_eval.sv
// evaluation of one event: result words, next tracking state, class record
module tkec_eval import tkec_pkg::*; (
  input  in_word_t                      word_i,
  input  dev_lookup_t                   look_i,
  input  track_state_t                  state_i,
  input  logic [15:0]                   tap_distance_i,
  output logic [1:0]                    count_o,
  output out_word_t [MaxResults-1:0]    slot_o,
  output track_state_t                  state_o,
  output dev_write_t                    wr_o
);

  logic is_key, is_abs, is_sync, is_touch, new_dev;
  logic has_b, gesture, seq_err, key_ok;
  out_word_t w_new, w_b, w_gest, w_seq, w_key;

  logic signed [31:0] sx, sy;
  logic [32:0]        dx, dy, mx, my;

  always_comb begin
    is_key   = word_i.event_type == EvKey;
    is_abs   = word_i.event_type == EvAbs;
    is_sync  = (word_i.event_type == EvSyn) && (word_i.event_code == SynReport);
    new_dev  = (is_key || is_abs) && look_i.in_table && !look_i.known;
    is_touch = look_i.in_table && look_i.known && look_i.touch;
    key_ok   = (word_i.event_code <= KeyLowMax) ||
               ((word_i.event_code >= KeyHighMin) && (word_i.event_code <= KeyHighMax));

    has_b   = (is_key && !is_touch && state_i.touch_active) ||
              (is_abs && (word_i.event_code == AbsMtTrack));
    gesture = state_i.touch_active && (state_i.contact_count == 8'sd0);
    seq_err = state_i.key_pending &&
              ((state_i.held_key_index + 32'd1) != word_i.event_index);

    w_new             = '0;
    w_new.notice_kind = KindNewDevice;
    w_new.device_out  = word_i.device_id;
    w_new.detail      = is_abs;
    w_new.first_index = word_i.event_index;

    w_b            = '0;
    w_b.device_out = word_i.device_id;
    if (is_key) begin
      w_b.notice_kind = KindError;
    end else begin
      w_b.notice_kind     = KindTracking;
      w_b.report_value    = word_i.event_value;
      w_b.contacts_before = state_i.contact_count;
    end

    w_gest               = '0;
    w_gest.notice_kind   = KindGesture;
    w_gest.device_out    = word_i.device_id;
    w_gest.detail        = state_i.swipe_seen;
    w_gest.first_index   = state_i.touch_start_index;
    w_gest.closing_index = word_i.event_index;

    w_seq             = '0;
    w_seq.notice_kind = KindError;
    w_seq.device_out  = word_i.device_id;
    w_seq.detail      = 1'b1;

    w_key               = '0;
    w_key.notice_kind   = KindKey;
    w_key.device_out    = word_i.device_id;
    w_key.first_index   = state_i.held_key_index;
    w_key.closing_index = word_i.event_index;
    w_key.key_code_out  = state_i.held_key_code;
    w_key.report_value  = state_i.held_key_value;

    // pack the words that fire into the lowest slots
    if (is_sync) begin
      count_o   = 2'(gesture) + 2'(state_i.key_pending) + 2'(seq_err);
      slot_o[0] = gesture ? w_gest : (seq_err ? w_seq : w_key);
      slot_o[1] = (gesture && seq_err) ? w_seq : w_key;
      slot_o[2] = w_key;
    end else begin
      count_o   = 2'(new_dev) + 2'(has_b);
      slot_o[0] = new_dev ? w_new : w_b;
      slot_o[1] = w_b;
      slot_o[2] = w_b;
    end

    wr_o.en    = new_dev;
    wr_o.dev   = word_i.device_id;
    wr_o.touch = is_abs;

    // axis travel from the start position
    sx = state_i.start_x_valid ? state_i.start_x : word_i.event_value;
    sy = state_i.start_y_valid ? state_i.start_y : word_i.event_value;
    dx = {sx[31], sx} - {word_i.event_value[31], word_i.event_value};
    dy = {sy[31], sy} - {word_i.event_value[31], word_i.event_value};
    mx = dx[32] ? (33'd0 - dx) : dx;
    my = dy[32] ? (33'd0 - dy) : dy;

    state_o = state_i;
    if (is_key) begin
      if (is_touch ? key_ok : !state_i.touch_active) begin
        state_o.key_pending    = 1'b1;
        state_o.held_key_code  = word_i.event_code;
        state_o.held_key_value = word_i.event_value;
        state_o.held_key_index = word_i.event_index;
      end
    end else if (is_abs) begin
      if (word_i.event_code == AbsMtTrack) begin
        if (word_i.event_value != -32'sd1) begin
          if (state_i.contact_count == 8'sd0) begin
            state_o.first_tracking_value = word_i.event_value;
            state_o.touch_start_index    = word_i.event_index;
            state_o.touch_active         = 1'b1;
          end
          // a lower id than the first one does not add a contact
          if (!((state_i.contact_count > 8'sd0) &&
                (word_i.event_value < state_i.first_tracking_value)) &&
              (state_i.contact_count != 8'sd127)) begin
            state_o.contact_count = state_i.contact_count + 8'sd1;
          end
        end else if (state_i.contact_count != -8'sd128) begin
          state_o.contact_count = state_i.contact_count - 8'sd1;
        end
      end else if (word_i.event_code == AbsMtX) begin
        state_o.start_x       = sx;
        state_o.start_x_valid = 1'b1;
        if (mx > 33'(tap_distance_i)) begin
          state_o.swipe_seen = 1'b1;
        end
      end else if (word_i.event_code == AbsMtY) begin
        state_o.start_y       = sy;
        state_o.start_y_valid = 1'b1;
        if (my > 33'(tap_distance_i)) begin
          state_o.swipe_seen = 1'b1;
        end
      end
    end else if (is_sync) begin
      if (gesture) begin
        state_o.touch_active         = 1'b0;
        state_o.contact_count        = '0;
        state_o.first_tracking_value = '0;
        state_o.touch_start_index    = '0;
        state_o.swipe_seen           = 1'b0;
        state_o.start_x              = '0;
        state_o.start_x_valid        = 1'b0;
        state_o.start_y              = '0;
        state_o.start_y_valid        = 1'b0;
      end
      if (state_i.key_pending) begin
        state_o.key_pending    = 1'b0;
        state_o.held_key_code  = '0;
        state_o.held_key_value = '0;
        state_o.held_key_index = '0;
      end
    end
  end

endmodule
